FILE: src/pidsp_pkg.sv
// Shared constants, control word types and the microcode program of the PID servo block.
`timescale 1ns / 1ps
`default_nettype none

package pidsp_pkg;

    // Angle scale: one full turn of the sensor.
    localparam int ANGLE_FULL_SCALE = 4096;
    localparam int ANGLE_BITS       = $clog2(ANGLE_FULL_SCALE);
    // Rounded divide by a quarter turn is an arithmetic shift.
    localparam int PID_SHIFT        = ANGLE_BITS - 2;
    localparam int PID_HALF         = 1 << (PID_SHIFT - 1);

    // Q2.14 drive scale.
    localparam int ONE_Q14          = 16384;
    localparam int DRIVE_FRAC       = 14;

    // Multiplier operand and product widths.
    localparam int MUL_W            = 17;
    localparam int PROD_W           = 2 * MUL_W;

    // Step counter.
    localparam int STEP_W           = 3;

    // Multiplier operand selection.
    localparam logic [2:0] MUL_NONE   = 3'd0;
    localparam logic [2:0] MUL_GI_ERR = 3'd1;
    localparam logic [2:0] MUL_GP_ERR = 3'd2;
    localparam logic [2:0] MUL_GD_DC  = 3'd3;
    localparam logic [2:0] MUL_PULSE  = 3'd4;

    // Accumulator operation.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    // Write-back target.
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_PREP  = 3'd1;
    localparam logic [2:0] WR_INTEG = 3'd2;
    localparam logic [2:0] WR_DRIVE = 3'd3;
    localparam logic [2:0] WR_OUT   = 3'd4;

    // Program step addresses.
    localparam logic [STEP_W-1:0] STEP_PREP    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_I   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_INTEG   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LOAD_P  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SUB_D   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DRIVE   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_MUL_PW  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_OUT     = 3'd7;

    // One microcode word.
    typedef struct packed {
        logic [2:0]        mul;
        logic [1:0]        acc;
        logic [2:0]        wr;
        logic              jmp_idle;
        logic [STEP_W-1:0] jmp_to;
        logic              last;
    } t_uword;

    // Control group from the sequencer to the datapath.
    typedef struct packed {
        logic   busy;
        t_uword uw;
    } t_ctrl;

    // Microcode program. The first step skips the PID part when the loop is idle.
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, jmp_idle: 1'b0,
              jmp_to: STEP_PREP, last: 1'b0};
        unique case (step)
            STEP_PREP: begin
                w.wr       = WR_PREP;
                w.jmp_idle = 1'b1;
                w.jmp_to   = STEP_MUL_PW;
            end
            STEP_MUL_I: begin
                w.mul = MUL_GI_ERR;
            end
            STEP_INTEG: begin
                w.wr  = WR_INTEG;
                w.mul = MUL_GP_ERR;
            end
            STEP_LOAD_P: begin
                w.acc = ACC_LOAD;
                w.mul = MUL_GD_DC;
            end
            STEP_SUB_D: begin
                w.acc = ACC_SUB;
            end
            STEP_DRIVE: begin
                w.wr = WR_DRIVE;
            end
            STEP_MUL_PW: begin
                w.mul = MUL_PULSE;
            end
            STEP_OUT: begin
                // Keep the pulse product in place while the output stalls.
                w.mul  = MUL_PULSE;
                w.wr   = WR_OUT;
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/pidsp_seq.sv
// Step counter and microcode fetch for the PID servo block.
`timescale 1ns / 1ps
`default_nettype none

module pidsp_seq
    import pidsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_stall,
    input  wire logic  i_loop_idle,
    output t_ctrl      o_ctrl
);

    logic              r_busy;
    logic              n_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;

    // Fetch the control word of the current step.
    assign uw = ucode_rom(r_step);

    // Next step: start, advance, jump, or finish once the result is placed.
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = STEP_PREP;
            end
        end else if (uw.last) begin
            if (!i_stall) begin
                n_busy = 1'b0;
            end
        end else if (uw.jmp_idle && i_loop_idle) begin
            n_step = uw.jmp_to;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_PREP;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_ctrl.busy = r_busy;
    assign o_ctrl.uw   = uw;

endmodule

`default_nettype wire

FILE: src/pid_angle_to_servo_pulse_core.sv
// Top level of the PID servo block: registers, shared multiplier datapath and stream ports.
//
//  Channel   Direction  Handshake                 Beat contents
//  s_axis    in         tvalid / tready           angle sample, manual drive, load flag
//  m_axis    out        tvalid / tready           drive value, pulse ticks, pulse enable
//  apb       in/out     psel, penable, pready     8 registers at byte addresses 4*i
//
// A beat is accepted only while the program is idle, so the next beat waits until the
// program for the last one has finished; with the loop idle the PID steps are skipped.
// The single shared 17x17 multiplier serves four products of the program in sequence.
// Reset is synchronous and active low; it restores the register defaults and clears state.
// A finished result waits in the output register; a new beat is taken meanwhile, and the
// program holds only at its last step if the previous result has not yet been taken.
`timescale 1ns / 1ps
`default_nettype none

module pid_angle_to_servo_pulse_core
    import pidsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // angle_sample[11:0], manual_drive[27:12]
    input  wire logic [0:0]  s_axis_tuser,   // load_manual[0]
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // drive_value[15:0], pulse_ticks[31:16]
    output logic [0:0]       m_axis_tuser,   // pulse_enabled[0]
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Register indexes.
    localparam logic [2:0] REG_GOAL    = 3'd0;
    localparam logic [2:0] REG_MODE    = 3'd1;
    localparam logic [2:0] REG_GAIN_P  = 3'd2;
    localparam logic [2:0] REG_GAIN_I  = 3'd3;
    localparam logic [2:0] REG_GAIN_D  = 3'd4;
    localparam logic [2:0] REG_MIN     = 3'd5;
    localparam logic [2:0] REG_NEUTRAL = 3'd6;
    localparam logic [2:0] REG_MAX     = 3'd7;

    localparam logic [1:0]  MODE_NONE     = 2'd0;
    localparam logic [1:0]  MODE_POSITION = 2'd1;
    localparam logic [12:0] GOAL_NONE     = 13'(ANGLE_FULL_SCALE);

    // Saturate a wide signed value to the Q2.14 range -1..+1.
    function automatic logic signed [15:0] clamp_one(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] res;
        if (v > PROD_W'(ONE_Q14)) begin
            res = 16'(ONE_Q14);
        end else if (v < -PROD_W'(ONE_Q14)) begin
            res = -16'(ONE_Q14);
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [12:0]        r_goal;
    logic [1:0]         r_mode;
    logic signed [15:0] r_gain_p;
    logic signed [15:0] r_gain_i;
    logic signed [15:0] r_gain_d;
    logic [15:0]        r_min;
    logic [15:0]        r_neutral;
    logic [15:0]        r_max;

    // Loop state.
    logic signed [15:0] r_drive;
    logic signed [15:0] r_integ;
    logic [ANGLE_BITS-1:0] r_prev;
    logic               r_prev_valid;

    // Captured input beat.
    logic [ANGLE_BITS-1:0] r_sample;
    logic               r_load;
    logic signed [15:0] r_manual;

    // Datapath registers.
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;

    // Output register.
    logic               r_out_valid;
    logic signed [15:0] r_out_drive;
    logic [15:0]        r_out_ticks;
    logic               r_out_en;

    t_ctrl ctrl;
    logic  in_acc;
    logic  cfg_wr;
    logic  mode_wr;
    logic  loop_idle;
    logic  stall;
    logic  do_out;
    logic  pulse_en;
    logic [2:0] reg_idx;

    logic signed [ANGLE_BITS-1:0] err;
    logic signed [ANGLE_BITS:0]   dc;
    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic signed [MUL_W-1:0]      delta;
    logic [15:0]                  drive_neg;
    logic [DRIVE_FRAC:0]          drive_mag;
    logic signed [PROD_W-1:0]     integ_sum;
    logic signed [PROD_W-1:0]     drive_sum;
    logic signed [PROD_W-1:0]     ticks_sum;

    // Handshakes.
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !ctrl.busy;
    assign pready        = 1'b1;
    assign reg_idx       = paddr[4:2];
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign mode_wr       = cfg_wr && (reg_idx == REG_MODE);

    assign loop_idle = !((r_mode == MODE_POSITION) && (r_goal < GOAL_NONE));
    assign stall     = r_out_valid && !m_axis_tready;
    assign do_out    = ctrl.busy && (ctrl.uw.wr == WR_OUT) && !stall;

    pidsp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_stall     (stall),
        .i_loop_idle (loop_idle),
        .o_ctrl      (ctrl)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal    <= GOAL_NONE;
            r_mode    <= MODE_NONE;
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_min     <= 16'd2400;
            r_neutral <= 16'd12960;
            r_max     <= 16'd22200;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GOAL:    r_goal    <= pwdata[12:0];
                REG_MODE:    r_mode    <= pwdata[1:0];
                REG_GAIN_P:  r_gain_p  <= pwdata[15:0];
                REG_GAIN_I:  r_gain_i  <= pwdata[15:0];
                REG_GAIN_D:  r_gain_d  <= pwdata[15:0];
                REG_MIN:     r_min     <= pwdata[15:0];
                REG_NEUTRAL: r_neutral <= pwdata[15:0];
                REG_MAX:     r_max     <= pwdata[15:0];
                default:     r_goal    <= r_goal;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            REG_GOAL:    prdata = {19'd0, r_goal};
            REG_MODE:    prdata = {30'd0, r_mode};
            REG_GAIN_P:  prdata = {16'd0, r_gain_p};
            REG_GAIN_I:  prdata = {16'd0, r_gain_i};
            REG_GAIN_D:  prdata = {16'd0, r_gain_d};
            REG_MIN:     prdata = {16'd0, r_min};
            REG_NEUTRAL: prdata = {16'd0, r_neutral};
            REG_MAX:     prdata = {16'd0, r_max};
            default:     prdata = '0;
        endcase
    end

    // Capture the input beat.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= s_axis_tdata[ANGLE_BITS-1:0];
            r_manual <= s_axis_tdata[27:12];
            r_load   <= s_axis_tuser[0];
        end
    end

    // Wrapped angle error and measurement change.
    assign err = r_goal[ANGLE_BITS-1:0] - r_sample;
    assign dc  = r_prev_valid ? ($signed({1'b0, r_sample}) - $signed({1'b0, r_prev}))
                              : '0;

    // Pulse interpolation operands: span toward the end point and drive magnitude.
    assign delta     = r_drive[15] ? ($signed({1'b0, r_min}) - $signed({1'b0, r_neutral}))
                                   : ($signed({1'b0, r_max}) - $signed({1'b0, r_neutral}));
    assign drive_neg = -r_drive;
    assign drive_mag = r_drive[15] ? drive_neg[DRIVE_FRAC:0] : r_drive[DRIVE_FRAC:0];

    // Shared multiplier operand selection.
    always_comb begin
        case (ctrl.uw.mul)
            MUL_GI_ERR: begin
                mul_a = MUL_W'(r_gain_i);
                mul_b = MUL_W'(err);
            end
            MUL_GP_ERR: begin
                mul_a = MUL_W'(r_gain_p);
                mul_b = MUL_W'(err);
            end
            MUL_GD_DC: begin
                mul_a = MUL_W'(r_gain_d);
                mul_b = MUL_W'(dc);
            end
            MUL_PULSE: begin
                mul_a = delta;
                mul_b = $signed({{(MUL_W-DRIVE_FRAC-1){1'b0}}, drive_mag});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Accumulator for the proportional minus derivative term.
    always_ff @(posedge i_clk) begin
        case (ctrl.uw.acc)
            ACC_LOAD: r_acc <= r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    // Rounded updates of the integral and the drive.
    assign integ_sum = PROD_W'(r_integ) + ((r_prod + PROD_W'(PID_HALF)) >>> PID_SHIFT);
    assign drive_sum = PROD_W'(r_integ) + ((r_acc + PROD_W'(PID_HALF)) >>> PID_SHIFT);
    assign ticks_sum = $signed({{(PROD_W-16){1'b0}}, r_neutral}) + (r_prod >>> DRIVE_FRAC);

    // Loop state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive      <= '0;
            r_integ      <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (mode_wr) begin
            r_integ      <= '0;
            r_prev_valid <= 1'b0;
        end else if (ctrl.busy) begin
            case (ctrl.uw.wr)
                WR_PREP: begin
                    if (r_load) begin
                        r_drive <= clamp_one(PROD_W'(r_manual));
                    end
                end
                WR_INTEG: begin
                    r_integ <= clamp_one(integ_sum);
                end
                WR_DRIVE: begin
                    r_drive      <= clamp_one(drive_sum);
                    r_prev       <= r_sample;
                    r_prev_valid <= 1'b1;
                end
                default: begin
                    r_drive <= r_drive;
                end
            endcase
        end
    end

    // Pulse output enable.
    assign pulse_en = (r_max != 16'd0) && (r_min != 16'd0) && (r_min < r_max);

    // Output register: loaded at the last step, emptied when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_out) begin
            r_out_drive <= r_drive;
            r_out_ticks <= pulse_en ? ticks_sum[15:0] : 16'd0;
            r_out_en    <= pulse_en;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ticks, r_out_drive};
    assign m_axis_tuser  = r_out_en;

    // The stored drive always lies within -1..+1.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive <= 16'sd16384) && (r_drive >= -16'sd16384))
        else $error("drive store out of range");

    // The integral always lies within -1..+1.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= 16'sd16384) && (r_integ >= -16'sd16384))
        else $error("integral out of range");

    // The previous sample is dropped only by a mode write.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_prev_valid) |-> $past(mode_wr))
        else $error("previous sample dropped without mode write");

    // A new result appears only at the end of a running program.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(ctrl.busy) && $fell(ctrl.busy))
        else $error("result produced outside the last step");

endmodule

`default_nettype wire

FILE: tb/sv/servo_pulse_checker.sv
// Register and mode codes for the servo bench, and the checker that predicts and compares result beats.
`timescale 1ns / 1ps

package servo_tb_pkg;

    // Register indexes; register i sits at byte address 4*i.
    typedef enum logic [2:0] {
        REG_GOAL_ANGLE,
        REG_LOOP_MODE,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_MIN_PULSE,
        REG_NEUTRAL_PULSE,
        REG_MAX_PULSE
    } servo_reg_e;

    // Loop modes; only position mode runs the PID step.
    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_POSITION,
        MODE_SPEED,
        MODE_OFF
    } loop_mode_e;

endpackage

module servo_pulse_checker
    import pidsp_pkg::*, servo_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream as seen on the bus
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // angle_sample[11:0], manual_drive[27:12]
    input  logic [0:0]  i_in_user,    // load_manual[0]
    // Output stream as seen on the bus
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // drive_value[15:0], pulse_ticks[31:16]
    input  logic [0:0]  i_out_user,   // pulse_enabled[0]
    // Configuration writes
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    // Status for the stimulus side
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic [15:0] drive;
        logic [15:0] ticks;
        logic        enabled;
    } pulse_result_t;

    // Register copy.
    logic [12:0]        cfg_goal;
    loop_mode_e         cfg_mode;
    logic signed [15:0] cfg_gain_p;
    logic signed [15:0] cfg_gain_i;
    logic signed [15:0] cfg_gain_d;
    logic [15:0]        cfg_min_ticks;
    logic [15:0]        cfg_neutral_ticks;
    logic [15:0]        cfg_max_ticks;

    // Controller state.
    logic signed [15:0] drive_q14;
    logic signed [15:0] integ_q14;
    logic [12:0]        last_angle;
    logic               last_valid;

    pulse_result_t expected_beats[$];
    int            error_count = 0;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    // Saturate to the Q2.14 range -1..+1.
    function automatic logic signed [15:0] clamp_unit(input longint v);
        if (v > ONE_Q14)
            return 16'(ONE_Q14);
        if (v < -ONE_Q14)
            return 16'(-ONE_Q14);
        return 16'(v);
    endfunction

    // Round x*4/FS to nearest with halves going up; FS is a power of two.
    function automatic longint quarter_turn_round(input longint x);
        return (8 * x + ANGLE_FULL_SCALE) >>> (ANGLE_BITS + 1);
    endfunction

    // One control slot: optional manual load, PID step when running, then the pulse map.
    function automatic pulse_result_t predict_beat(input logic [11:0] angle, input logic load,
                                                   input logic signed [15:0] manual);
        longint        err;
        longint        rate;
        longint        d;
        longint        ticks;
        pulse_result_t res;
        if (load)
            drive_q14 = clamp_unit(longint'(manual));
        if (cfg_mode == MODE_POSITION && cfg_goal < ANGLE_FULL_SCALE) begin
            // Wrapped error; a half-turn offset lands on the negative side.
            err = longint'(cfg_goal) - longint'(angle);
            if (err < 0)
                err += ANGLE_FULL_SCALE;
            if (2 * err >= ANGLE_FULL_SCALE)
                err -= ANGLE_FULL_SCALE;
            integ_q14 = clamp_unit(longint'(integ_q14) +
                                   quarter_turn_round(longint'(cfg_gain_i) * err));
            // Derivative on the measurement, without wrap, and zero on the first sample.
            rate = last_valid ? longint'(angle) - longint'(last_angle) : 64'sd0;
            last_angle = 13'(angle);
            last_valid = 1'b1;
            drive_q14 = clamp_unit(quarter_turn_round(longint'(cfg_gain_p) * err -
                                                      longint'(cfg_gain_d) * rate) +
                                   longint'(integ_q14));
        end
        res.drive   = drive_q14;
        res.enabled = cfg_max_ticks != 0 && cfg_min_ticks != 0 && cfg_min_ticks < cfg_max_ticks;
        ticks = 0;
        if (res.enabled) begin
            // Interpolate from neutral toward max for positive drive, toward min otherwise.
            d = longint'(drive_q14);
            if (d >= 0)
                ticks = (d * cfg_max_ticks + (ONE_Q14 - d) * cfg_neutral_ticks) / ONE_Q14;
            else
                ticks = (-d * cfg_min_ticks + (ONE_Q14 + d) * cfg_neutral_ticks) / ONE_Q14;
            if (ticks > 65535)
                ticks = 65535;
        end
        res.ticks = 16'(ticks);
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: check failed, %s", $time, msg);
        error_count++;
    endtask

    // Track register writes, compare result beats and queue a prediction per input beat.
    always @(posedge i_clk) begin
        pulse_result_t seen;
        pulse_result_t want;
        if (!i_rst_n) begin
            cfg_goal          = 13'(ANGLE_FULL_SCALE);
            cfg_mode          = MODE_NONE;
            cfg_gain_p        = '0;
            cfg_gain_i        = '0;
            cfg_gain_d        = '0;
            cfg_min_ticks     = 16'd2400;
            cfg_neutral_ticks = 16'd12960;
            cfg_max_ticks     = 16'd22200;
            drive_q14         = '0;
            integ_q14         = '0;
            last_angle        = '0;
            last_valid        = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (servo_reg_e'(i_paddr[4:2]))
                    REG_GOAL_ANGLE: cfg_goal = i_pwdata[12:0];
                    REG_LOOP_MODE: begin
                        // A mode write restarts the integral and the derivative history.
                        cfg_mode   = loop_mode_e'(i_pwdata[1:0]);
                        integ_q14  = '0;
                        last_valid = 1'b0;
                    end
                    REG_GAIN_P:        cfg_gain_p = i_pwdata[15:0];
                    REG_GAIN_I:        cfg_gain_i = i_pwdata[15:0];
                    REG_GAIN_D:        cfg_gain_d = i_pwdata[15:0];
                    REG_MIN_PULSE:     cfg_min_ticks = i_pwdata[15:0];
                    REG_NEUTRAL_PULSE: cfg_neutral_ticks = i_pwdata[15:0];
                    REG_MAX_PULSE:     cfg_max_ticks = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                seen = '{drive: i_out_data[15:0], ticks: i_out_data[31:16],
                         enabled: i_out_user[0]};
                if (expected_beats.size() == 0) begin
                    flag_mismatch("result beat arrived with nothing expected");
                end else begin
                    want = expected_beats.pop_front();
                    if (seen.drive !== want.drive)
                        flag_mismatch($sformatf("drive_value got %0d expected %0d",
                                                $signed(seen.drive), $signed(want.drive)));
                    if (seen.ticks !== want.ticks)
                        flag_mismatch($sformatf("pulse_ticks got %0d expected %0d",
                                                seen.ticks, want.ticks));
                    if (seen.enabled !== want.enabled)
                        flag_mismatch($sformatf("pulse_enabled got %b expected %b",
                                                seen.enabled, want.enabled));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_beats.push_back(predict_beat(i_in_data[11:0], i_in_user[0],
                                                      i_in_data[27:12]));
        end
        o_pending <= expected_beats.size();
        o_errors  <= error_count;
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the PID servo bench: clock, reset, register setup, beat stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import pidsp_pkg::*;
    import servo_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BEATS  = 700;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // angle_sample[11:0], manual_drive[27:12]
    logic [0:0]  s_axis_tuser  = '0;   // load_manual[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // drive_value[15:0], pulse_ticks[31:16]
    logic [0:0]  m_axis_tuser;         // pulse_enabled[0]
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int          tx_idle_pct = 9;
    int          rx_idle_pct = 52;
    int          cycle_count = 0;
    int          pending_results;
    int          error_total;
    logic [12:0] goal_now = 13'(ANGLE_FULL_SCALE);

    pid_angle_to_servo_pulse_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    servo_pulse_checker pulse_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending_results),
        .o_errors    (error_total)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side stalls at random according to the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one input beat and hold it until taken, then maybe leave a gap.
    task automatic send_sample(input logic [11:0] angle, input logic load,
                               input logic [15:0] manual);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, manual, angle};
        s_axis_tuser  <= load;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Stop sending until every predicted beat has come back, then let the block settle.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycle, then the bus returns to idle.
    task automatic apb_write(input servo_reg_e idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_GOAL_ANGLE)
            goal_now = value[12:0];
    endtask

    // Write the whole register set once the block is idle.
    task automatic load_settings(input logic [12:0] goal, input loop_mode_e mode,
                                 input logic [15:0] gp, input logic [15:0] gi,
                                 input logic [15:0] gd, input logic [15:0] lo,
                                 input logic [15:0] mid, input logic [15:0] hi);
        hold_until_drained();
        apb_write(REG_GOAL_ANGLE, 32'(goal));
        apb_write(REG_GAIN_P, 32'(gp));
        apb_write(REG_GAIN_I, 32'(gi));
        apb_write(REG_GAIN_D, 32'(gd));
        apb_write(REG_MIN_PULSE, 32'(lo));
        apb_write(REG_NEUTRAL_PULSE, 32'(mid));
        apb_write(REG_MAX_PULSE, 32'(hi));
        apb_write(REG_LOOP_MODE, 32'(mode));
    endtask

    initial begin
        int          sent;
        int          run_len;
        logic [12:0] goal;
        loop_mode_e  mode;
        logic [15:0] gains[3];
        logic [15:0] lo;
        logic [15:0] mid;
        logic [15:0] hi;
        logic [11:0] angle;
        logic [15:0] manual;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults: loop idle, so the stored drive maps straight to a pulse.
        send_sample(12'd0, 1'b0, 16'd0);
        send_sample(12'hFFF, 1'b1, 16'd16384);
        send_sample(12'd2048, 1'b1, 16'hC000);
        send_sample(12'd1, 1'b1, 16'h7FFF);        // manual value above +1 clamps
        send_sample(12'd2, 1'b1, 16'h8000);        // and below -1 as well
        send_sample(12'd3, 1'b1, 16'd8191);
        send_sample(12'd4, 1'b0, 16'h5555);        // payload ignored without the load flag

        // Moderate PID around a goal of 1000, including both half-turn edges.
        load_settings(13'd1000, MODE_POSITION, 16'd4096, 16'd410, 16'd2048,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd1000, 1'b0, 16'd0);
        send_sample(12'd900, 1'b0, 16'd0);
        send_sample(12'd3048, 1'b0, 16'd0);
        send_sample(12'd3049, 1'b0, 16'd0);
        send_sample(12'd0, 1'b1, 16'd12000);       // manual load then overwritten by PID
        send_sample(12'hFFF, 1'b0, 16'd0);

        // Gain extremes drive the integral and the output into saturation.
        load_settings(13'd0, MODE_POSITION, 16'h7FFF, 16'h8000, 16'h7FFF,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd0, 1'b0, 16'd0);
        send_sample(12'hFFF, 1'b0, 16'd0);
        send_sample(12'd2048, 1'b0, 16'd0);
        load_settings(13'd4095, MODE_POSITION, 16'h8000, 16'h7FFF, 16'h8000,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd0, 1'b0, 16'd0);
        send_sample(12'hFFF, 1'b0, 16'd0);

        // No goal: the loop holds the drive.
        load_settings(13'(ANGLE_FULL_SCALE), MODE_POSITION, 16'd4096, 16'd0, 16'd0,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd123, 1'b1, 16'd5000);
        load_settings(13'h1FFF, MODE_POSITION, 16'd4096, 16'd0, 16'd0,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd321, 1'b0, 16'd0);

        // Speed mode and the unused mode code do nothing.
        load_settings(13'd500, MODE_SPEED, 16'd4096, 16'd4096, 16'd0,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd0, 1'b1, 16'hE000);
        load_settings(13'd500, MODE_OFF, 16'd4096, 16'd4096, 16'd0,
                      16'd2400, 16'd12960, 16'd22200);
        send_sample(12'd7, 1'b0, 16'd0);

        // Pulse disabled by a zero min, by min equal to max, and by a zero max.
        load_settings(13'd500, MODE_NONE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd12960, 16'd22200);
        send_sample(12'd0, 1'b1, 16'd16384);
        load_settings(13'd500, MODE_NONE, 16'd0, 16'd0, 16'd0, 16'd5000, 16'd12960, 16'd5000);
        send_sample(12'd0, 1'b0, 16'd0);
        load_settings(13'd500, MODE_NONE, 16'd0, 16'd0, 16'd0, 16'd2400, 16'd12960, 16'd0);
        send_sample(12'd0, 1'b0, 16'd0);

        // Widest legal pulse range.
        load_settings(13'd500, MODE_NONE, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF);
        send_sample(12'd0, 1'b1, 16'd16384);
        send_sample(12'd0, 1'b1, 16'hC000);
        send_sample(12'd0, 1'b1, 16'd8192);

        // Random runs, each under fresh register settings, over three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 52 : 0;
            rx_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 9 : 0;
            sent = 0;
            while (sent < RANDOM_BEATS / 3) begin
                case ($urandom_range(0, 9))
                    0:       goal = 13'(ANGLE_FULL_SCALE);
                    1:       goal = 13'($urandom_range(ANGLE_FULL_SCALE + 1, 8191));
                    2:       goal = 13'd0;
                    3:       goal = 13'(ANGLE_FULL_SCALE - 1);
                    default: goal = 13'($urandom_range(0, ANGLE_FULL_SCALE - 1));
                endcase
                mode = ($urandom_range(0, 3) == 0) ? loop_mode_e'($urandom_range(0, 3))
                                                   : MODE_POSITION;
                foreach (gains[g]) begin
                    case ($urandom_range(0, 5))
                        0:       gains[g] = 16'h7FFF;
                        1:       gains[g] = 16'h8000;
                        2:       gains[g] = 16'($urandom);
                        default: gains[g] = 16'($urandom_range(0, 1024) - 512);
                    endcase
                end
                case ($urandom_range(0, 5))
                    0: begin
                        lo  = 16'($urandom);
                        mid = 16'($urandom);
                        hi  = 16'($urandom);
                    end
                    1: begin
                        lo  = 16'd1;
                        mid = 16'($urandom);
                        hi  = 16'hFFFF;
                    end
                    default: begin
                        lo  = 16'($urandom_range(1, 30000));
                        hi  = 16'($urandom_range(lo + 1, 65535));
                        mid = 16'($urandom_range(lo, hi));
                    end
                endcase
                load_settings(goal, mode, gains[0], gains[1], gains[2], lo, mid, hi);

                run_len = $urandom_range(15, 50);
                repeat (run_len) begin
                    // Half the samples stay near the goal so the loop leaves saturation.
                    if (goal_now < ANGLE_FULL_SCALE && $urandom_range(0, 1) == 1)
                        angle = 12'(goal_now + $urandom_range(0, 128) - 64);
                    else
                        angle = 12'($urandom);
                    case ($urandom_range(0, 7))
                        0:       manual = 16'd16384;
                        1:       manual = 16'hC000;
                        2:       manual = 16'($urandom);
                        default: manual = 16'($urandom_range(0, 32768) - 16384);
                    endcase
                    send_sample(angle, $urandom_range(0, 3) == 0, manual);
                    if ($urandom_range(0, 99) == 0)
                        hold_until_drained();
                end
                sent += run_len;
            end
        end

        hold_until_drained();
        if (error_total == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
